// ----- design/mma_pkg.sv -----
// Shared types and constants for the mouse motion accelerator.
`default_nettype none

package mma_pkg;

  localparam int ACCUM_WIDTH_DEF = 32;
  localparam int GAIN_W          = 16;
  localparam int THRESH_W        = 8;
  localparam int DELTA_W         = 16;
  localparam int BUTTON_W        = 32;
  localparam int MOTION_W        = 24;
  localparam int CFG_DATA_W      = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'h0299;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'h10;

  typedef enum logic [1:0] {
    ACT_POLL   = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_PEEK   = 2'd3
  } action_t;

  typedef enum logic {
    REG_SPEED_GAIN      = 1'b0,
    REG_ACCEL_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t                    action;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  delta_z;
    logic        [BUTTON_W-1:0] buttons_in;
  } in_req_t;

  typedef struct packed {
    logic signed [MOTION_W-1:0] motion_x;
    logic signed [MOTION_W-1:0] motion_y;
    logic signed [MOTION_W-1:0] motion_z;
    logic        [BUTTON_W-1:0] buttons_out;
  } out_req_t;

endpackage

`default_nettype wire

// ----- design/mma_stream_if.sv -----
// Valid/ready stream channel carrying one request payload.
`default_nettype none

interface mma_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/mouse_motion_accelerator.sv -----
// Mouse motion accelerator: thresholded gain, saturating motion accumulators, button OR.
//
// Usage:
//   in_ch carries one request per handshake (valid & ready): poll start, motion
//   report (x/y/z deltas and a button mask), read-and-clear or peek.
//   out_ch returns one request for each read or peek: accumulated motion / 256
//   truncated toward zero, and the buttons ORed since the last poll start.
//   Poll start and report requests produce nothing on out_ch.
//   cfg_we writes cfg_wdata to register cfg_index (0 speed gain, 1 threshold);
//   write only while no request is in flight.
// Timing:
//   One request is taken every cycle unless in_ch.ready is low (see Stall). The
//   two squares, the gain select and the three scaled deltas are formed as a
//   request enters the input register; the saturating accumulate and the output
//   division happen as it leaves that register, and out_valid_r is set as a read
//   or peek leaves it. With out_ch ready, throughput is one request per cycle.
// Reset (rst_n low, synchronous): accumulators and buttons clear, gain 0x299,
//   threshold 0x10, both channels empty.
// Stall: while out_ch is held, reports keep flowing through; a read or peek
//   waits in the input register and in_ch.ready drops behind it.
`default_nettype none

module mouse_motion_accelerator #(
  parameter int ACCUM_WIDTH = mma_pkg::ACCUM_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mma_stream_if.sink                          in_ch,
  mma_stream_if.source                        out_ch,
  input  wire logic                           cfg_we,
  input  wire mma_pkg::cfg_reg_t              cfg_index,
  input  wire logic [mma_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SCALED_W = mma_pkg::DELTA_W + mma_pkg::GAIN_W + 1;
  localparam int SUM_W    = ((ACCUM_WIDTH > SCALED_W) ? ACCUM_WIDTH : SCALED_W) + 1;
  localparam int QUOT_W   = ACCUM_WIDTH - 8;
  localparam int EXT_W    = (QUOT_W > mma_pkg::MOTION_W) ? QUOT_W : mma_pkg::MOTION_W;
  localparam int MAG_W    = 2 * mma_pkg::DELTA_W + 1;

  localparam logic signed [SUM_W-1:0] ACC_HI =
    SUM_W'({1'b0, {(ACCUM_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);
  localparam logic signed [EXT_W-1:0] Q_MAX  = EXT_W'(26'sd8388607);
  localparam logic signed [EXT_W-1:0] Q_MIN  = EXT_W'(-26'sd8388608);

  mma_pkg::in_req_t  in_req;
  mma_pkg::out_req_t out_nxt;

  logic [mma_pkg::GAIN_W-1:0]   speed_gain_r;
  logic [mma_pkg::THRESH_W-1:0] accel_threshold_r;

  // input register (stage 1)
  logic                           s1_valid_r;
  mma_pkg::action_t               s1_action_r;
  logic signed [SCALED_W-1:0]     s1_sx_r, s1_sy_r, s1_sz_r;
  logic [mma_pkg::BUTTON_W-1:0]   s1_buttons_r;

  // state
  logic signed [ACCUM_WIDTH-1:0]  accum_x_r, accum_y_r, accum_z_r;
  logic [mma_pkg::BUTTON_W-1:0]   button_state_r;

  logic                           out_valid_r;
  mma_pkg::out_req_t              out_data_r;

  logic in_fire, s1_has_result, s1_go;

  // stage 1 arithmetic
  logic signed [2*mma_pkg::DELTA_W-1:0] sq_x, sq_y;
  logic signed [MAG_W-1:0]              mag;
  logic [2*mma_pkg::THRESH_W-1:0]       thr;
  logic                                 fast;
  logic signed [SCALED_W-1:0]           px, py, pz, ux, uy, uz;
  logic signed [mma_pkg::GAIN_W:0]      gain_s;

  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] acc,
    input logic signed [SCALED_W-1:0]    d
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(d);
    if (s > ACC_HI)      return ACC_HI[ACCUM_WIDTH-1:0];
    else if (s < ACC_LO) return ACC_LO[ACCUM_WIDTH-1:0];
    else                 return s[ACCUM_WIDTH-1:0];
  endfunction

  // divide by 256 toward zero, then clamp into the output range
  function automatic logic signed [mma_pkg::MOTION_W-1:0] to_motion(
    input logic signed [ACCUM_WIDTH-1:0] acc
  );
    logic signed [ACCUM_WIDTH-1:0] adj;
    logic signed [QUOT_W-1:0]      q;
    logic signed [EXT_W-1:0]       qe;
    adj = acc + (acc[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(255) : '0);
    q   = adj[ACCUM_WIDTH-1:8];
    qe  = EXT_W'(q);
    if (qe > Q_MAX)      qe = Q_MAX;
    else if (qe < Q_MIN) qe = Q_MIN;
    return qe[mma_pkg::MOTION_W-1:0];
  endfunction

  assign in_req        = in_ch.data;
  assign s1_has_result = (s1_action_r == mma_pkg::ACT_READ) ||
                         (s1_action_r == mma_pkg::ACT_PEEK);
  assign s1_go         = s1_valid_r && (!s1_has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || s1_go;
  assign in_fire       = in_ch.valid && in_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  always_comb begin
    sq_x   = in_req.delta_x * in_req.delta_x;
    sq_y   = in_req.delta_y * in_req.delta_y;
    mag    = MAG_W'(sq_x) + MAG_W'(sq_y);
    thr    = accel_threshold_r * accel_threshold_r;
    fast   = mag > $signed({1'b0, MAG_W'(thr)});
    gain_s = $signed({1'b0, speed_gain_r});
    px     = SCALED_W'(in_req.delta_x * gain_s);
    py     = SCALED_W'(in_req.delta_y * gain_s);
    pz     = SCALED_W'(in_req.delta_z * gain_s);
    ux     = SCALED_W'(in_req.delta_x) <<< 8;
    uy     = SCALED_W'(in_req.delta_y) <<< 8;
    uz     = SCALED_W'(in_req.delta_z) <<< 8;
  end

  always_comb begin
    out_nxt.motion_x    = to_motion(accum_x_r);
    out_nxt.motion_y    = to_motion(accum_y_r);
    out_nxt.motion_z    = to_motion(accum_z_r);
    out_nxt.buttons_out = button_state_r;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r      <= mma_pkg::GAIN_RESET;
      accel_threshold_r <= mma_pkg::THRESH_RESET;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      accum_x_r         <= '0;
      accum_y_r         <= '0;
      accum_z_r         <= '0;
      button_state_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mma_pkg::REG_SPEED_GAIN:      speed_gain_r      <= cfg_wdata;
          mma_pkg::REG_ACCEL_THRESHOLD:
            accel_threshold_r <= cfg_wdata[mma_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end

      if (in_fire)    s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;

      if (s1_go && s1_has_result) out_valid_r <= 1'b1;
      else if (out_ch.ready)      out_valid_r <= 1'b0;

      if (s1_go) begin
        unique case (s1_action_r)
          mma_pkg::ACT_POLL: begin
            button_state_r <= '0;
          end
          mma_pkg::ACT_REPORT: begin
            accum_x_r      <= sat_add(accum_x_r, s1_sx_r);
            accum_y_r      <= sat_add(accum_y_r, s1_sy_r);
            accum_z_r      <= sat_add(accum_z_r, s1_sz_r);
            button_state_r <= button_state_r | s1_buttons_r;
          end
          mma_pkg::ACT_READ: begin
            accum_x_r   <= '0;
            accum_y_r   <= '0;
            accum_z_r   <= '0;
          end
          mma_pkg::ACT_PEEK: ;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r  <= in_req.action;
      s1_sx_r      <= fast ? px : ux;
      s1_sy_r      <= fast ? py : uy;
      s1_sz_r      <= fast ? pz : uz;
      s1_buttons_r <= in_req.buttons_in;
    end
    if (s1_go && s1_has_result) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
